// ===== rtl/fps_pkg.sv =====
// Shared constants and types for the frame pacing scheduler.
// Holds field widths, register indexes and action codes; no dependencies.
package fps_pkg;

  localparam int TIME_WIDTH      = 40;
  localparam int COUNT_WIDTH     = 32;
  localparam int ALPHA_FRAC_BITS = 8;
  localparam int ID_WIDTH        = 32;
  localparam int IVL_WIDTH       = 20;
  localparam int CFG_DATA_WIDTH  = 20;
  localparam int CFG_INDEX_WIDTH = 2;

  // Averaging weight limits: 0.01 and 0.99 of one, rounded to nearest.
  localparam int ALPHA_ONE = 1 << ALPHA_FRAC_BITS;
  localparam int ALPHA_MIN = (ALPHA_ONE + 50) / 100;
  localparam int ALPHA_MAX = ALPHA_ONE - ALPHA_MIN;

  localparam logic [IVL_WIDTH-1:0]       INTERVAL_RESET = IVL_WIDTH'(33333);
  localparam logic [ALPHA_FRAC_BITS-1:0] ALPHA_RESET    = ALPHA_FRAC_BITS'(26);

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FRAME_INTERVAL = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SMOOTHING_ON   = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ALPHA          = 2'd2;

  // Event codes on the func field.
  localparam logic FUNC_FRAME   = 1'b0;
  localparam logic FUNC_DISPLAY = 1'b1;

  typedef enum logic [1:0] {
    ACT_DISPLAY   = 2'd0,
    ACT_DROP      = 2'd1,
    ACT_DUPLICATE = 2'd2,
    ACT_NO_FRAME  = 2'd3
  } action_t;

endpackage

// ===== rtl/frame_pacing_scheduler_unit.sv =====
// Frame pacing scheduler: drop/display/duplicate decisions and averaged display interval.
// Depends on fps_pkg for widths, register indexes and action codes.
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------------------------
//   in      | in_valid/in_ready  | func, frame_tag, pts_us, display_time_us
//   out     | out_valid/out_ready| action, echo_tag, scheduled_pts_us, counters,
//           |                    | mean_period_us
//   cfg     | cfg_wr_en          | cfg_index, cfg_data (write only, no wait)
//
// One transaction per cycle sustained while out_ready is high; a transaction passes through
// the input register and then the result register before its result is valid.
// The input register and the result register each hold one transaction, so input is
// taken while a result waits. The decision and the averaging multiply-add sit between
// those two registers. Reset (rst, synchronous) clears control and scheduler state and
// loads defaults. A stalled output holds its result; in_ready drops once the input is full.
module frame_pacing_scheduler_unit
  import fps_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,

  input  logic                        cfg_wr_en,
  input  logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]   cfg_data,

  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        func,
  input  logic signed [ID_WIDTH-1:0]  frame_tag,
  input  logic [TIME_WIDTH-1:0]       pts_us,
  input  logic [TIME_WIDTH-1:0]       display_time_us,

  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  action,
  output logic signed [ID_WIDTH-1:0]  echo_tag,
  output logic [TIME_WIDTH-1:0]       scheduled_pts_us,
  output logic [COUNT_WIDTH-1:0]      total_count,
  output logic [COUNT_WIDTH-1:0]      displayed_count,
  output logic [COUNT_WIDTH-1:0]      dropped_count,
  output logic [COUNT_WIDTH-1:0]      duplicated_count,
  output logic [TIME_WIDTH-1:0]       mean_period_us
);

  localparam int PROD_WIDTH = TIME_WIDTH + ALPHA_FRAC_BITS;

  // Configuration registers.
  logic [IVL_WIDTH-1:0]       frame_interval_us;
  logic                       smoothing_on;
  logic [ALPHA_FRAC_BITS-1:0] alpha_q8;

  // Input register.
  logic                       in_full;
  logic                       s_func;
  logic [ID_WIDTH-1:0]        s_tag;
  logic [TIME_WIDTH-1:0]      s_pts;
  logic [TIME_WIDTH-1:0]      s_disp;

  // Scheduler state.
  logic [TIME_WIDTH-1:0]      last_shown_pts;
  logic                       seen_first_frame;
  logic [COUNT_WIDTH-1:0]     total_ctr;
  logic [COUNT_WIDTH-1:0]     displayed_ctr;
  logic [COUNT_WIDTH-1:0]     dropped_ctr;
  logic [COUNT_WIDTH-1:0]     duplicated_ctr;
  logic [TIME_WIDTH-1:0]      mean_period;
  logic [TIME_WIDTH-1:0]      last_display_time;
  logic                       seen_first_display;

  // Next values computed from the held transaction.
  action_t                    action_next;
  logic [TIME_WIDTH-1:0]      sched_next;
  logic [TIME_WIDTH-1:0]      last_shown_pts_next;
  logic                       seen_first_frame_next;
  logic [COUNT_WIDTH-1:0]     total_ctr_next;
  logic [COUNT_WIDTH-1:0]     displayed_ctr_next;
  logic [COUNT_WIDTH-1:0]     dropped_ctr_next;
  logic [COUNT_WIDTH-1:0]     duplicated_ctr_next;
  logic [TIME_WIDTH-1:0]      mean_period_next;
  logic                       seen_first_display_next;

  logic                       advance;
  logic [IVL_WIDTH-1:0]       half_win;
  logic [IVL_WIDTH-1:0]       win_lo;
  logic [IVL_WIDTH:0]         win_hi;
  logic [TIME_WIDTH-1:0]      delta;
  logic [TIME_WIDTH-1:0]      disp_interval;
  logic [ALPHA_FRAC_BITS-1:0] alpha_clamped;
  logic [ALPHA_FRAC_BITS:0]   beta;
  logic [PROD_WIDTH-1:0]      prod_new;
  logic [PROD_WIDTH-1:0]      prod_old;
  logic [PROD_WIDTH:0]        blend_sum;

  // The held transaction moves on when the result register is free or being emptied.
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_interval_us <= INTERVAL_RESET;
      smoothing_on      <= 1'b1;
      alpha_q8          <= ALPHA_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FRAME_INTERVAL: frame_interval_us <= cfg_data[IVL_WIDTH-1:0];
        REG_SMOOTHING_ON:   smoothing_on      <= cfg_data[0];
        REG_ALPHA:          alpha_q8          <= cfg_data[ALPHA_FRAC_BITS-1:0];
        default:            ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_func <= func;
      s_tag  <= frame_tag;
      s_pts  <= pts_us;
      s_disp <= display_time_us;
    end
  end

  // Frame decision window around the expected timestamp.
  assign half_win = frame_interval_us >> 1;
  assign win_lo   = frame_interval_us - half_win;
  assign win_hi   = {1'b0, frame_interval_us} + {1'b0, half_win};
  assign delta    = s_pts - last_shown_pts;

  // Weighted average: (a*new + (1-a)*old + half) >> F, rounded half up.
  always_comb begin
    if (alpha_q8 < ALPHA_FRAC_BITS'(ALPHA_MIN)) begin
      alpha_clamped = ALPHA_FRAC_BITS'(ALPHA_MIN);
    end else if (alpha_q8 > ALPHA_FRAC_BITS'(ALPHA_MAX)) begin
      alpha_clamped = ALPHA_FRAC_BITS'(ALPHA_MAX);
    end else begin
      alpha_clamped = alpha_q8;
    end
  end

  assign disp_interval = s_disp - last_display_time;
  assign beta          = (ALPHA_FRAC_BITS + 1)'(ALPHA_ONE) - {1'b0, alpha_clamped};
  assign prod_new      = PROD_WIDTH'(disp_interval) * PROD_WIDTH'(alpha_clamped);
  assign prod_old      = PROD_WIDTH'(mean_period) * PROD_WIDTH'(beta);
  assign blend_sum     = {1'b0, prod_new} + {1'b0, prod_old}
                       + (PROD_WIDTH + 1)'(ALPHA_ONE >> 1);

  // Event processing and state next values.
  always_comb begin
    action_next             = ACT_NO_FRAME;
    sched_next              = '0;
    last_shown_pts_next     = last_shown_pts;
    seen_first_frame_next   = seen_first_frame;
    total_ctr_next          = total_ctr;
    displayed_ctr_next      = displayed_ctr;
    dropped_ctr_next        = dropped_ctr;
    duplicated_ctr_next     = duplicated_ctr;
    mean_period_next        = mean_period;
    seen_first_display_next = seen_first_display;

    if (s_func == FUNC_FRAME) begin
      if (total_ctr != '1) total_ctr_next = total_ctr + 1'b1;

      priority if (!seen_first_frame) begin
        action_next = ACT_DISPLAY;
      end else if (s_pts < last_shown_pts) begin
        action_next = ACT_DROP;
      end else if (delta < TIME_WIDTH'(win_lo)) begin
        action_next = ACT_DROP;
      end else if (delta > TIME_WIDTH'(win_hi)) begin
        action_next = ACT_DUPLICATE;
      end else begin
        action_next = ACT_DISPLAY;
      end

      unique case (action_next)
        ACT_DISPLAY: begin
          sched_next            = s_pts;
          last_shown_pts_next   = s_pts;
          seen_first_frame_next = 1'b1;
          if (displayed_ctr != '1) displayed_ctr_next = displayed_ctr + 1'b1;
        end
        ACT_DROP: begin
          sched_next = last_shown_pts;
          if (dropped_ctr != '1) dropped_ctr_next = dropped_ctr + 1'b1;
        end
        default: begin
          sched_next = last_shown_pts + TIME_WIDTH'(frame_interval_us);
          if (duplicated_ctr != '1) duplicated_ctr_next = duplicated_ctr + 1'b1;
        end
      endcase
    end else begin
      // The first display time only seeds the average; later ones must advance.
      if (!seen_first_display) begin
        mean_period_next        = TIME_WIDTH'(frame_interval_us);
        seen_first_display_next = 1'b1;
      end else if (s_disp > last_display_time) begin
        if (smoothing_on) begin
          mean_period_next = blend_sum[PROD_WIDTH-1:ALPHA_FRAC_BITS];
        end else begin
          mean_period_next = disp_interval;
        end
      end
    end
  end

  // State update when a transaction moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_shown_pts     <= '0;
      seen_first_frame   <= 1'b0;
      total_ctr          <= '0;
      displayed_ctr      <= '0;
      dropped_ctr        <= '0;
      duplicated_ctr     <= '0;
      mean_period        <= TIME_WIDTH'(INTERVAL_RESET);
      last_display_time  <= '0;
      seen_first_display <= 1'b0;
    end else if (advance) begin
      last_shown_pts     <= last_shown_pts_next;
      seen_first_frame   <= seen_first_frame_next;
      total_ctr          <= total_ctr_next;
      displayed_ctr      <= displayed_ctr_next;
      dropped_ctr        <= dropped_ctr_next;
      duplicated_ctr     <= duplicated_ctr_next;
      mean_period        <= mean_period_next;
      seen_first_display <= seen_first_display_next;
      if (s_func == FUNC_DISPLAY) last_display_time <= s_disp;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      action           <= action_next;
      echo_tag         <= (s_func == FUNC_FRAME) ? s_tag : '0;
      scheduled_pts_us <= sched_next;
      total_count      <= total_ctr_next;
      displayed_count  <= displayed_ctr_next;
      dropped_count    <= dropped_ctr_next;
      duplicated_count <= duplicated_ctr_next;
      mean_period_us   <= mean_period_next;
    end
  end

endmodule
